// ----- src/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, constants and the star-closure function of the wildcard
// pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int POS_W       = MAX_PATTERN + 1;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;

  localparam logic [1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [1:0] REG_LENGTH     = 2'd2;

  typedef logic [MAX_PATTERN-1:0][CHAR_W-1:0] pattern_chars_t;
  typedef logic [POS_W-1:0]                   pos_vec_t;

  typedef struct packed {
    pattern_chars_t chars;
    logic [LEN_W-1:0] len;
  } pattern_t;

  // Keep positions 0..len, then let every active star reach the next position.
  function automatic pos_vec_t close_over_stars(
    input pos_vec_t                 set_in,
    input logic [MAX_PATTERN-1:0]   star,
    input logic [LEN_W-1:0]         len
  );
    pos_vec_t kept;
    pos_vec_t res;
    logic     term;
    for (int j = 0; j < POS_W; j++) begin
      kept[j] = (LEN_W'(j) <= len) ? set_in[j] : 1'b0;
    end
    for (int j = 0; j < POS_W; j++) begin
      res[j] = 1'b0;
      for (int q = 0; q <= j; q++) begin
        term = kept[q];
        for (int k = 0; k < MAX_PATTERN; k++) begin
          if (k >= q && k < j) begin
            term = term & star[k];
          end
        end
        res[j] = res[j] | term;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/wpm_cfg.sv -----
// ----------------------------------------------------------------------------
// wpm_cfg
// APB register file holding the pattern characters and the pattern length.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cfg import wpm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output pattern_t               pattern
);

  logic [DATA_W-1:0] chars_low_r,  chars_low_nxt;
  logic [DATA_W-1:0] chars_high_r, chars_high_nxt;
  logic [LEN_W-1:0]  length_r,     length_nxt;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];

  always_comb begin
    chars_low_nxt  = chars_low_r;
    chars_high_nxt = chars_high_r;
    length_nxt     = length_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CHARS_LOW:  chars_low_nxt  = pwdata;
        REG_CHARS_HIGH: chars_high_nxt = pwdata;
        REG_LENGTH:     length_nxt     = pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
      length_r     <= '0;
    end else begin
      chars_low_r  <= chars_low_nxt;
      chars_high_r <= chars_high_nxt;
      length_r     <= length_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHARS_LOW:  prdata = chars_low_r;
      REG_CHARS_HIGH: prdata = chars_high_r;
      REG_LENGTH:     prdata = {{(DATA_W-LEN_W){1'b0}}, length_r};
      default:        prdata = '0;
    endcase
  end

  assign pattern.chars = {chars_high_r, chars_low_r};
  assign pattern.len   = length_r;

endmodule

`default_nettype wire

// ----- src/wpm_core.sv -----
// ----------------------------------------------------------------------------
// wpm_core
// Active-position vector and its one-character update with star closure.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_core import wpm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [CHAR_W-1:0] text_char,
  input  wire logic              has_char,
  input  wire logic              last,
  input  wire pattern_t          pattern,
  output logic                   matched
);

  pos_vec_t               active_r, active_nxt;
  pos_vec_t               cur;
  pos_vec_t               adv;
  pos_vec_t               after;
  pos_vec_t               fin;
  logic [LEN_W-1:0]       len;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] hit;

  assign len = (pattern.len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern.len;

  always_comb begin
    for (int p = 0; p < MAX_PATTERN; p++) begin
      star[p] = (LEN_W'(p) < len) && (pattern.chars[p] == STAR_CHAR);
      hit[p]  = (pattern.chars[p] == text_char) ||
                ((pattern.chars[p] == ANY_CHAR) && (text_char != DOT_CHAR));
    end
  end

  assign cur = close_over_stars(active_r, star, len);

  always_comb begin
    adv = '0;
    for (int p = 0; p < MAX_PATTERN; p++) begin
      if ((LEN_W'(p) < len) && cur[p]) begin
        if (star[p]) begin
          adv[p] = 1'b1;
        end else if (hit[p]) begin
          adv[p+1] = 1'b1;
        end
      end
    end
  end

  assign after   = has_char ? adv : active_r;
  assign fin     = close_over_stars(after, star, len);
  assign matched = fin[len];

  always_comb begin
    active_nxt = active_r;
    if (step) begin
      active_nxt = last ? pos_vec_t'(1) : after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= pos_vec_t'(1);
    end else begin
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/wildcard_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Glob matcher ('*' any run, '?' any character but '.') over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Program the pattern over APB (characters 0..7 at 0x00, 8..15 at 0x08,
//   length at 0x10) while no string is in flight. Send the string one byte
//   per transfer on the in_ channel; in_last marks its final transfer, and a
//   transfer with in_has_char low carries no byte (an empty string is one
//   such transfer with in_last high). The final transfer of each string
//   yields one out_ transfer with out_matched; other transfers yield none.
//   Throughput is one byte per cycle while in_stall is low. A final byte
//   passes through the input register, then its result is held in the
//   output register. The whole position vector updates combinationally
//   from the input register and feeds the output register.
//   While out_stall holds a result, bytes that give no result keep flowing;
//   the next final byte waits in the input register and in_stall rises.
//   Reset clears the pattern to empty, drops any byte or result in flight
//   and returns the matcher to the start position.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher import wpm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] in_text_char,
  input  wire logic              in_has_char,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_matched,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  pattern_t          pattern;
  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_has_char_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_matched_r;
  logic              out_free;
  logic              s1_fire;
  logic              in_take;
  logic              core_matched;

  wpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pattern (pattern)
  );

  wpm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .text_char (s1_char_r),
    .has_char  (s1_has_char_r),
    .last      (s1_last_r),
    .pattern   (pattern),
    .matched   (core_matched)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r     <= in_text_char;
      s1_has_char_r <= in_has_char;
      s1_last_r     <= in_last;
    end
    if (s1_fire && s1_last_r) begin
      out_matched_r <= core_matched;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  a_result_from_last : assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r)
  ) else $error("result without a final byte");

  a_stall_cause : assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall)
  ) else $error("input stalled without a blocked result");

  a_held_result : assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> !$past(s1_fire && s1_last_r)
  ) else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- sim/wpm_match_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wpm_match_checker
// Watches the byte stream, the pattern register writes and the result
// channel of the wildcard pattern matcher. It tracks the reachable pattern
// positions itself, queues the match verdict of every finished string and
// compares each result transfer with the oldest queued verdict.
// ----------------------------------------------------------------------------
module wpm_match_checker import wpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [CHAR_W-1:0] in_text_char,
  input  logic              in_has_char,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_matched,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                results_checked,
  output int                matches_seen
);

  pattern_chars_t   glob_chars;
  logic [LEN_W-1:0] glob_len;
  pos_vec_t         reachable;
  logic             expected_verdicts[$];

  function automatic int clamped_len();
    return (glob_len > MAX_PATTERN) ? MAX_PATTERN : int'(glob_len);
  endfunction

  function automatic pos_vec_t spread_stars(pos_vec_t s, int n);
    pos_vec_t r;
    r = '0;
    for (int p = 0; p <= n; p++) r[p] = s[p];
    for (int p = 0; p < n; p++) begin
      if (r[p] && glob_chars[p] == STAR_CHAR) r[p+1] = 1'b1;
    end
    return r;
  endfunction

  function automatic pos_vec_t consume_char(pos_vec_t s, logic [CHAR_W-1:0] c, int n);
    pos_vec_t cur;
    pos_vec_t nxt;
    cur = spread_stars(s, n);
    nxt = '0;
    for (int p = 0; p < n; p++) begin
      if (cur[p]) begin
        if (glob_chars[p] == STAR_CHAR) begin
          nxt[p] = 1'b1;
        end else if (glob_chars[p] == c || (glob_chars[p] == ANY_CHAR && c != DOT_CHAR)) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    matches_seen    = 0;
  end

  always @(posedge clk) begin : track
    int       n;
    pos_vec_t fin;
    logic     want;
    if (!rst_n) begin
      glob_chars = '0;
      glob_len   = '0;
      reachable  = pos_vec_t'(1);
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transfer: matched=%0b", out_matched);
        end else begin
          want = expected_verdicts.pop_front();
          results_checked++;
          if (want) matches_seen++;
          if (out_matched !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("string %0d: expected matched=%0b, got %0b",
                       results_checked, want, out_matched);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_CHARS_LOW:  glob_chars[7:0]  = pwdata;
          REG_CHARS_HIGH: glob_chars[15:8] = pwdata;
          REG_LENGTH:     glob_len         = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n = clamped_len();
        if (in_has_char) reachable = consume_char(reachable, in_text_char, n);
        if (in_last) begin
          fin = spread_stars(reachable, n);
          expected_verdicts.push_back(fin[n]);
          reachable = pos_vec_t'(1);
        end
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

// ----- sim/wildcard_pattern_matcher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_tb
// Drives pattern writes and byte strings into the wildcard pattern matcher:
// a directed opening on stars, '?' against '.', zero bytes, empty strings,
// oversized lengths and a pattern change inside a string, then random
// patterns with strings mostly derived from them. Both channels idle at
// random, one phase runs flat out and one holds the result side off long
// enough to back up the input. The checker instance judges every result.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_tb import wpm_pkg::*;;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  localparam int ITEM_TARGET   = 700;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 50;

  localparam logic [ADDR_W-1:0] ADDR_CHARS_LOW  = {REG_CHARS_LOW, 3'b000};
  localparam logic [ADDR_W-1:0] ADDR_CHARS_HIGH = {REG_CHARS_HIGH, 3'b000};
  localparam logic [ADDR_W-1:0] ADDR_LENGTH     = {REG_LENGTH, 3'b000};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid;
  logic              in_stall;
  logic [CHAR_W-1:0] in_text_char;
  logic              in_has_char;
  logic              in_last;
  logic              out_valid;
  logic              out_stall;
  logic              out_matched;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int results_checked;
  int matches_seen;
  int items_sent = 0;
  int cycle_count = 0;
  int pattern_count = 0;
  bit sender_idles;
  bit receiver_idles;
  bit hold_go;

  wildcard_pattern_matcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_text_char(in_text_char),
    .in_has_char(in_has_char), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_matched(out_matched),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wpm_match_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_text_char(in_text_char),
    .in_has_char(in_has_char), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_matched(out_matched),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending),
    .results_checked(results_checked), .matches_seen(matches_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL wildcard_pattern_matcher");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= receiver_idles && ($urandom_range(0, 99) < 38);
      end
    end
  end

  task automatic send_item(input logic [CHAR_W-1:0] c, input logic has, input logic lst);
    while (sender_idles && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_char <= c;
    in_has_char  <= has;
    in_last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input char_q_t txt, input bit end_empty);
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(txt[i], 1'b1, (i == txt.size() - 1) && !end_empty);
    end
    if (txt.size() == 0 || end_empty)
      send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drain: nothing queued, then let trailing non-final bytes clear the pipe.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] glob_byte();
    case ($urandom_range(0, 9))
      0: return 8'h61;
      1: return 8'h62;
      2: return DOT_CHAR;
      3, 4: return STAR_CHAR;
      5: return ANY_CHAR;
      6: return 8'h00;
      7: return 8'hFF;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] text_byte();
    case ($urandom_range(0, 7))
      0: return 8'h61;
      1: return 8'h62;
      2: return DOT_CHAR;
      3: return 8'h00;
      4: return 8'hFF;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic char_q_t text_from_glob(input pattern_chars_t pc, input int n);
    char_q_t          q;
    logic [CHAR_W-1:0] ch;
    for (int p = 0; p < n; p++) begin
      if (pc[p] == STAR_CHAR) begin
        repeat ($urandom_range(0, 3)) q.push_back(text_byte());
      end else if (pc[p] == ANY_CHAR) begin
        do ch = text_byte(); while (ch == DOT_CHAR);
        q.push_back(ch);
      end else begin
        q.push_back(pc[p]);
      end
    end
    if ($urandom_range(0, 3) == 0 && q.size() > 0)
      q[$urandom_range(0, q.size() - 1)] = text_byte();
    if ($urandom_range(0, 7) == 0) q.push_back(text_byte());
    if ($urandom_range(0, 7) == 0 && q.size() > 0) void'(q.pop_front());
    return q;
  endfunction

  function automatic char_q_t noise_text(input int max_len);
    char_q_t q;
    repeat ($urandom_range(0, max_len)) q.push_back(text_byte());
    return q;
  endfunction

  initial begin
    pattern_chars_t pc;
    int             plen;
    int             n;
    int             phase;
    int             random_start;
    int             phase_start;
    char_q_t        txt;

    in_valid       = 1'b0;
    in_text_char   = '0;
    in_has_char    = 1'b0;
    in_last        = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_go        = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty pattern after reset: only the empty string matches
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h78, 1'b1, 1'b1);

    // "a?*" followed by a zero byte
    settle();
    cfg_write(ADDR_CHARS_LOW, {32'h0, 8'h00, STAR_CHAR, ANY_CHAR, 8'h61});
    cfg_write(ADDR_CHARS_HIGH, 64'h0);
    cfg_write(ADDR_LENGTH, 64'd4);
    pattern_count++;
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(DOT_CHAR, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // oversized length clamps to the full pattern
    settle();
    cfg_write(ADDR_CHARS_LOW, {8{STAR_CHAR}});
    cfg_write(ADDR_CHARS_HIGH, {8'hFF, {7{STAR_CHAR}}});
    cfg_write(ADDR_LENGTH, 64'd31);
    pattern_count++;
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);

    // empty byte inside a string, then a length change inside a string
    settle();
    cfg_write(ADDR_CHARS_LOW, {48'h0, 8'h62, 8'h61});
    cfg_write(ADDR_CHARS_HIGH, 64'h0);
    cfg_write(ADDR_LENGTH, 64'd2);
    pattern_count++;
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    settle();
    cfg_write(ADDR_LENGTH, 64'd1);
    pattern_count++;
    send_item(8'h00, 1'b0, 1'b1);

    phase = 0;
    random_start = items_sent;
    while (items_sent - random_start < ITEM_TARGET) begin
      settle();
      case (phase % 7)
        1: begin
          pc = '1;
          plen = MAX_PATTERN;
        end
        2: begin
          pc = '0;
          plen = 0;
        end
        4: begin
          for (int p = 0; p < MAX_PATTERN; p++) pc[p] = glob_byte();
          plen = 31;
        end
        default: begin
          for (int p = 0; p < MAX_PATTERN; p++) pc[p] = glob_byte();
          plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31)
                                              : $urandom_range(0, MAX_PATTERN);
        end
      endcase
      cfg_write(ADDR_CHARS_LOW, pc[7:0]);
      cfg_write(ADDR_CHARS_HIGH, pc[15:8]);
      cfg_write(ADDR_LENGTH, {32'($urandom()), 27'($urandom()), 5'(plen)});
      pattern_count++;
      n = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;

      sender_idles   = (phase != 3);
      receiver_idles = (phase != 3);
      if (phase == 5) hold_go = 1'b1;

      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - random_start < ITEM_TARGET) begin
        if (phase == 5) txt = noise_text(2);
        else if ($urandom_range(0, 9) < 7) txt = text_from_glob(pc, n);
        else txt = noise_text(8);
        send_string(txt, $urandom_range(0, 9) == 0);
      end
      phase++;
    end

    settle();
    repeat (8) @(negedge clk);

    $display("checked %0d strings (%0d matching) from %0d input transfers",
             results_checked, matches_seen, items_sent);
    $display("under %0d pattern settings, %0d mismatches", pattern_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS wildcard_pattern_matcher");
    end else begin
      $display("FAIL wildcard_pattern_matcher");
    end
    $finish;
  end

endmodule
